[sv/vlfh_pkg.sv]
// Shared constants and types for the vertex layout fingerprint hash.
package vlfh_pkg;

    localparam int unsigned WORD_W = 64;
    localparam int unsigned HALF_W = 32;

    typedef logic [WORD_W-1:0] t_word;
    typedef logic [HALF_W-1:0] t_half;

    localparam t_word GOLDEN_STEP = 64'h9E37_79B9_7F4A_7C15;
    localparam t_word MIX_MUL_A   = 64'hBF58_476D_1CE4_E5B9;
    localparam t_word MIX_MUL_B   = 64'h94D0_49BB_1331_11EB;

    localparam int unsigned SHIFT_PRE  = 30;
    localparam int unsigned SHIFT_MID  = 27;
    localparam int unsigned SHIFT_POST = 31;

    // Index of the last packed word of a slot.
    localparam logic [1:0] LAST_WORD = 2'd3;

    // Slots in a full layout; framing itself only follows the first and last marks.
    localparam int unsigned SLOT_COUNT = 16;

endpackage

[sv/vlfh_if.sv]
// Valid/ready channel interfaces for attribute slots and fingerprints.
interface vlfh_in_if;
    logic                valid;
    logic                ready;
    logic                first_slot;
    logic                last_slot;
    logic [63:0]         ibo_address;
    logic                slot_enabled;
    logic [7:0]          attr_location;
    logic [31:0]         buffer_handle;
    logic signed [3:0]   component_count;
    logic [15:0]         data_type;
    logic [15:0]         stride_bytes;
    logic [31:0]         base_offset;
    logic                normalized;
    logic [63:0]         data_pointer;

    modport source (
        output valid, first_slot, last_slot, ibo_address, slot_enabled, attr_location,
               buffer_handle, component_count, data_type, stride_bytes, base_offset,
               normalized, data_pointer,
        input  ready
    );
    modport sink (
        input  valid, first_slot, last_slot, ibo_address, slot_enabled, attr_location,
               buffer_handle, component_count, data_type, stride_bytes, base_offset,
               normalized, data_pointer,
        output ready
    );
endinterface

interface vlfh_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] fingerprint;

    modport source (output valid, fingerprint, input ready);
    modport sink (input valid, fingerprint, output ready);
endinterface

[sv/vlfh_mul.sv]
// Iterative 64x64 low-half multiplier built on one shared 32x32 multiplier.
module vlfh_mul (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  vlfh_pkg::t_word i_a,
    input  vlfh_pkg::t_word i_b,
    output logic            o_done,
    output vlfh_pkg::t_word o_prod
);

    logic            r_busy;
    logic [1:0]      r_cnt;
    logic            r_done;
    vlfh_pkg::t_word r_a;
    vlfh_pkg::t_word r_b;
    vlfh_pkg::t_word r_prod;
    vlfh_pkg::t_word r_acc;
    vlfh_pkg::t_half op_x;
    vlfh_pkg::t_half op_y;

    // Partial products: lo*lo, then the two cross terms (only their low half matters).
    always_comb begin
        case (r_cnt)
            2'd0: begin
                op_x = r_a[vlfh_pkg::HALF_W-1:0];
                op_y = r_b[vlfh_pkg::HALF_W-1:0];
            end
            2'd1: begin
                op_x = r_a[vlfh_pkg::HALF_W-1:0];
                op_y = r_b[vlfh_pkg::WORD_W-1:vlfh_pkg::HALF_W];
            end
            default: begin
                op_x = r_a[vlfh_pkg::WORD_W-1:vlfh_pkg::HALF_W];
                op_y = r_b[vlfh_pkg::HALF_W-1:0];
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 2'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_a    <= i_a;
                r_b    <= i_b;
                r_busy <= 1'b1;
                r_cnt  <= 2'd0;
            end else if (r_busy) begin
                r_prod <= {{vlfh_pkg::HALF_W{1'b0}}, op_x} * {{vlfh_pkg::HALF_W{1'b0}}, op_y};
                r_cnt  <= r_cnt + 2'd1;
                case (r_cnt)
                    2'd0: begin
                    end
                    2'd1: begin
                        r_acc <= r_prod;
                    end
                    default: begin
                        r_acc <= r_acc + {r_prod[vlfh_pkg::HALF_W-1:0],
                                          {vlfh_pkg::HALF_W{1'b0}}};
                    end
                endcase
                if (r_cnt == 2'd3) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;

endmodule

[sv/vertex_layout_fingerprint_hash.sv]
// Vertex layout fingerprint: splitmix64 combine over packed attribute slot words.
// An enabled slot runs each of its four packed words through S_ADD, S_MA, S_WA, S_MB and
//   S_WB, then S_DONE; a disabled slot goes straight to S_DONE. Both mix multiplies use the
//   single shared 32x32 multiplier, iterated over partial products per 64-bit multiply.
// Not ready while a slot is folded or committed, or a fingerprint awaits the output register.
// Reset (synchronous, active low): sequencer idle, running hash zero, output empty.
module vertex_layout_fingerprint_hash (
    input  logic i_clk,
    input  logic i_rst_n,
    vlfh_in_if.sink    i_slot,
    vlfh_out_if.source o_fp
);

    // Sequencer states
    localparam logic [2:0] S_IDLE = 3'd0;  // wait for a slot
    localparam logic [2:0] S_ADD  = 3'd1;  // h + golden + word
    localparam logic [2:0] S_MA   = 3'd2;  // launch first mix multiply
    localparam logic [2:0] S_WA   = 3'd3;  // wait on first multiply
    localparam logic [2:0] S_MB   = 3'd4;  // launch second mix multiply
    localparam logic [2:0] S_WB   = 3'd5;  // wait on second multiply, finish the step
    localparam logic [2:0] S_DONE = 3'd6;  // commit and emit

    logic [2:0]      r_state;
    logic [2:0]      n_state;
    logic [1:0]      r_idx;
    vlfh_pkg::t_word r_h;

    // Latched slot fields
    logic            r_last;
    logic [7:0]      r_loc;
    logic [31:0]     r_handle;
    logic [3:0]      r_count;
    logic [15:0]     r_dtype;
    logic [15:0]     r_stride;
    logic [31:0]     r_offset;
    logic            r_norm;
    vlfh_pkg::t_word r_ptr;

    // Output register
    logic            r_out_valid;
    vlfh_pkg::t_word r_out_fp;

    logic            accept;
    logic            mul_start;
    logic            mul_done;
    vlfh_pkg::t_word mul_a;
    vlfh_pkg::t_word mul_b;
    vlfh_pkg::t_word mul_prod;
    vlfh_pkg::t_word word;
    logic            emit_ok;

    assign accept  = i_slot.valid && i_slot.ready;
    assign emit_ok = !r_out_valid || o_fp.ready;

    // Pack the word selected by the step counter.
    always_comb begin
        case (r_idx)
            2'd0:    word = {24'd0, r_loc, r_handle};
            2'd1:    word = {{28{r_count[3]}}, r_count, 16'd0, r_dtype};
            2'd2:    word = {15'd0, r_stride, r_offset, r_norm};
            default: word = r_ptr;
        endcase
    end

    // Both mix multiplies go through the same unit; operand shaping picks the round.
    assign mul_start = r_state inside {S_MA, S_MB};
    assign mul_a = (r_state == S_MA) ? (r_h ^ (r_h >> vlfh_pkg::SHIFT_PRE))
                                     : (r_h ^ (r_h >> vlfh_pkg::SHIFT_MID));
    assign mul_b = (r_state == S_MA) ? vlfh_pkg::MIX_MUL_A : vlfh_pkg::MIX_MUL_B;

    vlfh_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (mul_start),
        .i_a     (mul_a),
        .i_b     (mul_b),
        .o_done  (mul_done),
        .o_prod  (mul_prod)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_slot.slot_enabled ? S_ADD : S_DONE;
                end
            end
            S_ADD:  n_state = S_MA;
            S_MA:   n_state = S_WA;
            S_WA: begin
                if (mul_done) begin
                    n_state = S_MB;
                end
            end
            S_MB:   n_state = S_WB;
            S_WB: begin
                if (mul_done) begin
                    n_state = (r_idx == vlfh_pkg::LAST_WORD) ? S_DONE : S_ADD;
                end
            end
            S_DONE: begin
                // hold until the output register frees up for a final slot
                if (!r_last || emit_ok) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_idx       <= 2'd0;
            r_h         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;

            if (r_out_valid && o_fp.ready) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        // seed on the first slot, else keep folding into the held hash
                        if (i_slot.first_slot) begin
                            r_h <= i_slot.ibo_address;
                        end
                        r_idx    <= 2'd0;
                        r_last   <= i_slot.last_slot;
                        r_loc    <= i_slot.attr_location;
                        r_handle <= i_slot.buffer_handle;
                        r_count  <= i_slot.component_count;
                        r_dtype  <= i_slot.data_type;
                        r_stride <= i_slot.stride_bytes;
                        r_offset <= i_slot.base_offset;
                        r_norm   <= i_slot.normalized;
                        r_ptr    <= i_slot.data_pointer;
                    end
                end
                S_ADD: begin
                    r_h <= r_h + vlfh_pkg::GOLDEN_STEP + word;
                end
                S_WA: begin
                    if (mul_done) begin
                        r_h <= mul_prod;
                    end
                end
                S_WB: begin
                    if (mul_done) begin
                        r_h   <= mul_prod ^ (mul_prod >> vlfh_pkg::SHIFT_POST);
                        r_idx <= r_idx + 2'd1;
                    end
                end
                S_DONE: begin
                    if (r_last && emit_ok) begin
                        r_out_valid <= 1'b1;
                        r_out_fp    <= r_h;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign i_slot.ready     = (r_state == S_IDLE);
    assign o_fp.valid       = r_out_valid;
    assign o_fp.fingerprint = r_out_fp;

endmodule

[sv/vlfh_checker.sv]
// Port-level checker for the vertex layout fingerprint hash, with its bind.
module vlfh_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_first,
    input logic        i_last,
    input logic        i_enabled,
    input logic [63:0] i_ibo,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [63:0] i_fp
);

    logic in_xfer;
    assign in_xfer = i_in_valid && i_in_ready;

    // Reset empties the output register.
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("fingerprint valid after reset");

    // A stalled fingerprint holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_fp))
        else $error("stalled fingerprint changed");

    // An enabled slot keeps the block busy in the next cycle.
    a_busy_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_enabled |=> !i_in_ready)
        else $error("ready during fold");

    // A non-final slot never produces a fingerprint.
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && !i_last && !i_out_valid |=> !i_out_valid)
        else $error("fingerprint without final slot");

    // A lone disabled slot reports its seed through S_DONE and the output register.
    a_seed_pass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && i_first && i_last && !i_enabled && !i_out_valid
        |=> ##1 (i_out_valid && i_fp == $past(i_ibo, 2)))
        else $error("disabled slot did not pass seed");

endmodule

bind vertex_layout_fingerprint_hash vlfh_checker u_vlfh_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_slot.valid),
    .i_in_ready  (i_slot.ready),
    .i_first     (i_slot.first_slot),
    .i_last      (i_slot.last_slot),
    .i_enabled   (i_slot.slot_enabled),
    .i_ibo       (i_slot.ibo_address),
    .i_out_valid (o_fp.valid),
    .i_out_ready (o_fp.ready),
    .i_fp        (o_fp.fingerprint)
);
